// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define ASIMC_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define ASIMC_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- sv/asimc_pkg.sv -----
package asimc_pkg;

    // Field widths
    localparam int SENSOR_W   = 16;
    localparam int DEG_W      = 9;
    localparam int TOTAL_W    = 10;
    localparam int TIMER_W    = 16;
    localparam int KEY_W      = 8;
    localparam int TOL_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RAW_W      = 15;
    localparam int PROD_W     = RAW_W + DEG_W;

    // Angle constants in degrees
    localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;
    localparam logic [DEG_W-1:0] DEG_HALF = 9'd180;
    localparam logic [DEG_W-1:0] DEG_Q3   = 9'd270;
    localparam logic [DEG_W-1:0] DEG_Q1   = 9'd90;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 10'd1023;
    localparam logic [KEY_W-1:0]   KEY_TIMER_MAX = 8'd255;

    // Register reset values
    localparam logic [TIMER_W-1:0] RUN_INTERVAL_RST  = 16'd1500;
    localparam logic [TIMER_W-1:0] HOME_INTERVAL_RST = 16'd800;
    localparam logic [TOL_W-1:0]   HOME_TOL_RST      = 8'd15;
    localparam logic [TOTAL_W-1:0] STOP_COUNT_RST    = 10'd330;
    localparam logic [KEY_W-1:0]   DEBOUNCE_RST      = 8'd20;

    typedef enum logic [1:0] {
        DRIVE_STOP = 2'd0,
        DRIVE_CW   = 2'd1,
        DRIVE_CCW  = 2'd2
    } drive_t;

    typedef enum logic [1:0] {
        RUN_IDLE = 2'd0,
        RUN_FWD  = 2'd1,
        RUN_REV  = 2'd2
    } run_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_INTERVAL  = 3'd0,
        CFG_HOME_INTERVAL = 3'd1,
        CFG_HOME_TOL      = 3'd2,
        CFG_STOP_COUNT    = 3'd3,
        CFG_DEBOUNCE      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [TIMER_W-1:0] run_interval;
        logic [TIMER_W-1:0] home_interval;
        logic [TOL_W-1:0]   home_tol;
        logic [TOTAL_W-1:0] stop_count;
        logic [KEY_W-1:0]   debounce;
    } cfg_t;

    // One tick after angle conversion
    typedef struct packed {
        logic [DEG_W-1:0] deg;
        logic             cw_n;
        logic             ccw_n;
        logic             key_n;
    } tick_t;

    typedef struct packed {
        drive_t             motor_drive;
        run_t               run_mode;
        logic [TOTAL_W-1:0] travelled;
        logic               in_set_mode;
        logic [DEG_W-1:0]   origin_angle;
    } result_t;

    // ((raw << 1) * 360) >> 16 is the same as (raw * 360) >> 15
    function automatic logic [DEG_W-1:0] to_degrees(input logic [RAW_W-1:0] raw);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(raw) * PROD_W'(DEG_FULL);
        return prod[PROD_W-1:RAW_W];
    endfunction

endpackage

// ----- sv/asimc_ifs.sv -----
interface asimc_in_if;
    import asimc_pkg::*;
    logic                valid;
    logic                ready;
    logic [SENSOR_W-1:0] sensor_word;
    logic                cw_trigger_n;
    logic                ccw_trigger_n;
    logic                set_key_n;

    modport source (output valid, sensor_word, cw_trigger_n, ccw_trigger_n, set_key_n,
                    input ready);
    modport sink (input valid, sensor_word, cw_trigger_n, ccw_trigger_n, set_key_n,
                  output ready);
endinterface

interface asimc_out_if;
    import asimc_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         motor_drive;
    logic [1:0]         run_mode;
    logic [TOTAL_W-1:0] travelled;
    logic               in_set_mode;
    logic [DEG_W-1:0]   origin_angle;

    modport source (output valid, motor_drive, run_mode, travelled, in_set_mode,
                    origin_angle, input ready);
    modport sink (input valid, motor_drive, run_mode, travelled, in_set_mode,
                  origin_angle, output ready);
endinterface

interface asimc_cfg_if;
    import asimc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/asimc_cfg_regs.sv -----
module asimc_cfg_regs
    import asimc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    asimc_cfg_if.sink   cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the register index and take the low bits of the data
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_RUN_INTERVAL:  regs_next.run_interval  = cfg.data[TIMER_W-1:0];
                CFG_HOME_INTERVAL: regs_next.home_interval = cfg.data[TIMER_W-1:0];
                CFG_HOME_TOL:      regs_next.home_tol      = cfg.data[TOL_W-1:0];
                CFG_STOP_COUNT:    regs_next.stop_count    = cfg.data[TOTAL_W-1:0];
                CFG_DEBOUNCE:      regs_next.debounce      = cfg.data[KEY_W-1:0];
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.run_interval  <= RUN_INTERVAL_RST;
            regs_reg.home_interval <= HOME_INTERVAL_RST;
            regs_reg.home_tol      <= HOME_TOL_RST;
            regs_reg.stop_count    <= STOP_COUNT_RST;
            regs_reg.debounce      <= DEBOUNCE_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- sv/asimc_front.sv -----
module asimc_front
    import asimc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    asimc_in_if.sink   sensor,
    input  logic       take,
    output logic       tick_valid,
    output tick_t      tick
);

    logic  valid_reg;
    logic  valid_next;
    tick_t tick_reg;
    logic  load;

    // Refill whenever the held item is empty or leaves this cycle
    assign sensor.ready = !valid_reg || take;
    assign load         = sensor.valid && sensor.ready;
    assign valid_next   = load || (valid_reg && !take);
    assign tick_valid   = valid_reg;
    assign tick         = tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Convert the sensor word to degrees on the way in
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tick_reg.deg   <= to_degrees(sensor.sensor_word[RAW_W-1:0]);
            tick_reg.cw_n  <= sensor.cw_trigger_n;
            tick_reg.ccw_n <= sensor.ccw_trigger_n;
            tick_reg.key_n <= sensor.set_key_n;
        end
    end

endmodule

// ----- sv/asimc_core.sv -----
module asimc_core
    import asimc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_valid,
    input  tick_t       tick,
    input  cfg_t        cfg,
    output logic        take,
    asimc_out_if.source status
);

    logic               set_mode_reg,    set_mode_next;
    run_t               run_reg,         run_next;
    logic [TOTAL_W-1:0] total_reg,       total_next;
    logic [DEG_W-1:0]   ref_reg,         ref_next;
    logic [DEG_W-1:0]   origin_reg,      origin_next;
    logic [TIMER_W-1:0] timer_reg,       timer_next;
    logic [KEY_W-1:0]   key_timer_reg,   key_timer_next;
    logic               key_latched_reg, key_latched_next;
    drive_t             drive_reg,       drive_next;
    logic               out_valid_reg,   out_valid_next;
    result_t            res_reg;

    // Advance when a tick waits and the result slot is free or draining
    assign take           = tick_valid && (!out_valid_reg || status.ready);
    assign out_valid_next = take || (out_valid_reg && !status.ready);

    // One tick of control: key, set mode, triggers, run sample, home sample
    always_comb
    begin
        logic               run_hit;
        logic               home_hit;
        logic               moved;
        logic [TOTAL_W-1:0] add;
        logic [TOTAL_W:0]   sum;
        logic [TOTAL_W-1:0] wrap_sum;
        logic [DEG_W-1:0]   dev;
        logic [DEG_W-1:0]   tol;

        set_mode_next    = set_mode_reg;
        run_next         = run_reg;
        total_next       = total_reg;
        ref_next         = ref_reg;
        origin_next      = origin_reg;
        timer_next       = timer_reg;
        key_timer_next   = key_timer_reg;
        key_latched_next = key_latched_reg;
        drive_next       = drive_reg;
        run_hit          = 1'b0;
        home_hit         = 1'b0;
        moved            = 1'b0;
        add              = '0;
        sum              = '0;
        wrap_sum         = '0;
        dev              = '0;
        tol              = DEG_W'(cfg.home_tol);

        // Debounce the set key; an accepted press toggles set mode
        if (tick.key_n)
        begin
            key_latched_next = 1'b0;
            key_timer_next   = '0;
        end
        else if (!key_latched_reg)
        begin
            if (key_timer_reg < KEY_TIMER_MAX)
            begin
                key_timer_next = key_timer_reg + 1'b1;
            end
            if (key_timer_reg > cfg.debounce)
            begin
                key_latched_next = 1'b1;
                set_mode_next    = !set_mode_reg;
            end
        end

        if (set_mode_next)
        begin
            // Stop and capture the origin
            drive_next  = DRIVE_STOP;
            run_next    = RUN_IDLE;
            origin_next = tick.deg;
            ref_next    = tick.deg;
        end
        else
        begin
            // Start a run from idle, forward trigger first
            if (run_reg == RUN_IDLE)
            begin
                if (!tick.cw_n)
                begin
                    ref_next   = tick.deg;
                    run_next   = RUN_FWD;
                    total_next = '0;
                end
                else if (!tick.ccw_n)
                begin
                    ref_next   = tick.deg;
                    run_next   = RUN_REV;
                    total_next = '0;
                end
            end

            // Run sampling on the shared timer
            if (run_next != RUN_IDLE)
            begin
                run_hit = (timer_reg >= cfg.run_interval);
                timer_next = run_hit ? '0 : timer_reg + 1'b1;
            end
            if (run_hit)
            begin
                if (tick.deg != ref_next)
                begin
                    case (run_next)
                        RUN_REV:
                        begin
                            if (tick.deg > ref_next)
                            begin
                                add   = TOTAL_W'(tick.deg - ref_next);
                                moved = 1'b1;
                            end
                            else if (ref_next > DEG_Q3 && tick.deg < DEG_Q1)
                            begin
                                add   = TOTAL_W'(DEG_FULL - ref_next) + TOTAL_W'(tick.deg);
                                moved = 1'b1;
                            end
                        end
                        RUN_FWD:
                        begin
                            if (ref_next > tick.deg)
                            begin
                                add = TOTAL_W'(ref_next - tick.deg);
                            end
                            else
                            begin
                                add = TOTAL_W'(DEG_FULL - tick.deg) + TOTAL_W'(ref_next);
                            end
                            moved = 1'b1;
                        end
                        default:
                        begin
                            moved = 1'b0;
                        end
                    endcase
                end
                if (moved)
                begin
                    sum        = {1'b0, total_next} + {1'b0, add};
                    total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                    ref_next   = tick.deg;
                    if (total_next >= cfg.stop_count)
                    begin
                        run_next = RUN_IDLE;
                    end
                end
                case (run_next)
                    RUN_FWD: drive_next = DRIVE_CW;
                    RUN_REV: drive_next = DRIVE_CCW;
                    default: drive_next = DRIVE_STOP;
                endcase
            end

            // Homing sample, seeing the timer as the run sample left it
            if (run_next == RUN_IDLE)
            begin
                home_hit = (timer_next >= cfg.home_interval);
                timer_next = home_hit ? '0 : timer_next + 1'b1;
            end
            if (home_hit)
            begin
                wrap_sum = TOTAL_W'(tick.deg) + TOTAL_W'(DEG_FULL) - TOTAL_W'(origin_reg);
                dev = (wrap_sum >= TOTAL_W'(DEG_FULL)) ? DEG_W'(wrap_sum - TOTAL_W'(DEG_FULL))
                                                       : DEG_W'(wrap_sum);
                if (dev <= tol || (DEG_FULL - dev) <= tol)
                begin
                    drive_next = DRIVE_STOP;
                end
                else if (dev > DEG_HALF)
                begin
                    drive_next = DRIVE_CCW;
                end
                else if (dev < DEG_HALF)
                begin
                    drive_next = DRIVE_CW;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_mode_reg    <= 1'b0;
            run_reg         <= RUN_IDLE;
            total_reg       <= '0;
            ref_reg         <= '0;
            origin_reg      <= '0;
            timer_reg       <= '0;
            key_timer_reg   <= '0;
            key_latched_reg <= 1'b0;
            drive_reg       <= DRIVE_STOP;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                set_mode_reg    <= set_mode_next;
                run_reg         <= run_next;
                total_reg       <= total_next;
                ref_reg         <= ref_next;
                origin_reg      <= origin_next;
                timer_reg       <= timer_next;
                key_timer_reg   <= key_timer_next;
                key_latched_reg <= key_latched_next;
                drive_reg       <= drive_next;
            end
        end
    end

    // Hold the result item until it is taken
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg.motor_drive  <= drive_next;
            res_reg.run_mode     <= run_next;
            res_reg.travelled    <= total_next;
            res_reg.in_set_mode  <= set_mode_next;
            res_reg.origin_angle <= origin_next;
        end
    end

    assign status.valid        = out_valid_reg;
    assign status.motor_drive  = res_reg.motor_drive;
    assign status.run_mode     = res_reg.run_mode;
    assign status.travelled    = res_reg.travelled;
    assign status.in_set_mode  = res_reg.in_set_mode;
    assign status.origin_angle = res_reg.origin_angle;

endmodule

// ----- sv/angle_sensor_index_motor_controller.sv -----
// A result item passes the angle conversion register, loaded by the edge that accepts its
// input item, and then the result register, loaded when the result slot is free or draining.
// Throughput: one item per cycle unless the result stalls; state updates once per item.
// The input stage can take one more item while a result waits, up to two items in flight.
// Reset (rst_n low, asynchronous): motor stopped, idle, set mode off, counters and
// origin cleared, configuration registers back to their defaults.
module angle_sensor_index_motor_controller
    import asimc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    asimc_in_if.sink    sensor,
    asimc_out_if.source status,
    asimc_cfg_if.sink   cfg
);

    cfg_t  cfg_regs;
    tick_t tick;
    logic  tick_valid;
    logic  take;

    asimc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    asimc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sensor     (sensor),
        .take       (take),
        .tick_valid (tick_valid),
        .tick       (tick)
    );

    asimc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick       (tick),
        .cfg        (cfg_regs),
        .take       (take),
        .status     (status)
    );

endmodule

// ----- sv/asimc_checker.sv -----
`include "assert_macros.svh"

module asimc_checker
    import asimc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] motor_drive,
    input logic [1:0] run_mode,
    input logic [9:0] travelled,
    input logic       in_set_mode,
    input logic [8:0] origin_angle
);

    logic [1:0]  occ_reg;
    logic [1:0]  occ_next;
    logic [8:0]  last_origin_reg;
    logic        in_take;
    logic        out_take;
    logic        stalled;
    logic        stopped;
    logic [11:0] held_bits;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    // Flag a waiting result, a stopped idle status, and the bits a stall must hold
    assign stalled   = out_valid && !out_ready;
    assign stopped   = (motor_drive == DRIVE_STOP) && (run_mode == RUN_IDLE);
    assign held_bits = {motor_drive, travelled};

    // Track items in flight and the origin of the last result item
    always_comb
    begin
        occ_next = occ_reg;
        if (in_take && !out_take)
        begin
            occ_next = occ_reg + 2'd1;
        end
        else if (out_take && !in_take)
        begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg         <= 2'd0;
            last_origin_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (out_take)
            begin
                last_origin_reg <= origin_angle;
            end
        end
    end

    `ASIMC_CHECK(a_no_phantom, out_valid, occ_reg != 2'd0)
    `ASIMC_CHECK(a_depth, 1'b1, occ_reg != 2'd3)
    `ASIMC_CHECK(a_set_stops, out_valid && in_set_mode, stopped)
    `ASIMC_CHECK(a_origin_hold, out_valid && !in_set_mode, origin_angle == last_origin_reg)
    `ASIMC_CHECK_NEXT(a_stall_hold, stalled, out_valid && $stable(held_bits))

endmodule

bind angle_sensor_index_motor_controller asimc_checker u_asimc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sensor.valid),
    .in_ready     (sensor.ready),
    .out_valid    (status.valid),
    .out_ready    (status.ready),
    .motor_drive  (status.motor_drive),
    .run_mode     (status.run_mode),
    .travelled    (status.travelled),
    .in_set_mode  (status.in_set_mode),
    .origin_angle (status.origin_angle)
);
